FILE: rtl/core/y86_ifd_pkg.sv
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode package
// Request and response types, status and instruction codes, length table.
// ----------------------------------------------------------------------------
package y86_ifd_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    localparam logic [3:0] IC_HALT   = 4'h0;
    localparam logic [3:0] IC_NOP    = 4'h1;
    localparam logic [3:0] IC_RRMOVQ = 4'h2;
    localparam logic [3:0] IC_IRMOVQ = 4'h3;
    localparam logic [3:0] IC_RMMOVQ = 4'h4;
    localparam logic [3:0] IC_MRMOVQ = 4'h5;
    localparam logic [3:0] IC_OPQ    = 4'h6;
    localparam logic [3:0] IC_JXX    = 4'h7;
    localparam logic [3:0] IC_CALL   = 4'h8;
    localparam logic [3:0] IC_RET    = 4'h9;
    localparam logic [3:0] IC_PUSHQ  = 4'hA;
    localparam logic [3:0] IC_POPQ   = 4'hB;

    localparam logic [3:0] NO_REG  = 4'hF;
    localparam logic [3:0] FUN_MAX = 4'h6;

    typedef struct packed {
        logic [63:0] pc;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [63:0] following_quad;
    } t_fetch_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] constant_value;
        logic [63:0] next_pc;
    } t_fetch_rsp;

    // Instruction length in bytes; zero for an undefined icode.
    function automatic logic [3:0] len_of_icode(input logic [3:0] icode);
        logic [3:0] len;
        unique case (icode)
            IC_HALT, IC_NOP, IC_RET:            len = 4'd1;
            IC_RRMOVQ, IC_OPQ, IC_PUSHQ,
            IC_POPQ:                            len = 4'd2;
            IC_JXX, IC_CALL:                    len = 4'd9;
            IC_IRMOVQ, IC_RMMOVQ, IC_MRMOVQ:    len = 4'd10;
            default:                            len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/y86_instruction_fetch_decode_unit.sv
// ----------------------------------------------------------------------------
// Y86-64 instruction fetch/decode unit
// Request to response passes the subtract, classify and add stage registers.
// Throughput: one request per cycle while the output is not stalled.
// A stalled output holds the pipe; empty stages still fill behind it.
// Reset clears all stage valid bits and sets program_size to 0.
// ----------------------------------------------------------------------------
module y86_instruction_fetch_decode_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [63:0]              i_cfg_wdata,
    input  logic                     i_req_valid,
    output logic                     o_req_stall,
    input  y86_ifd_pkg::t_fetch_req  i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_stall,
    output y86_ifd_pkg::t_fetch_rsp  o_rsp
);

    logic [63:0] r_program_size;

    logic        r1_v;
    logic [64:0] r1_diff;
    y86_ifd_pkg::t_fetch_req r1_req;

    logic        r2_v;
    logic [63:0] r2_pc;
    logic [3:0]  r2_len;
    y86_ifd_pkg::t_fetch_rsp r2_rsp;

    logic        r3_v;
    y86_ifd_pkg::t_fetch_rsp r3_rsp;

    logic adv1, adv2, adv3;

    assign adv3 = !r3_v || !i_rsp_stall;
    assign adv2 = !r2_v || adv3;
    assign adv1 = !r1_v || adv2;

    assign o_req_stall = !adv1;
    assign o_rsp_valid = r3_v;
    assign o_rsp       = r3_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_size <= 64'd0;
        end else if (i_cfg_we) begin
            r_program_size <= i_cfg_wdata;
        end
    end

    // Stage 1: remaining bytes = program_size - pc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv1) begin
            r1_v <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_req  <= i_req;
            r1_diff <= {1'b0, r_program_size} - {1'b0, i_req.pc};
        end
    end

    // Stage 2: classify and pick fields
    logic [3:0] s2_icode, s2_ifun, s2_hi, s2_lo, s2_len;
    logic       s2_range, s2_invalid, s2_short;
    logic [3:0] n2_len;
    y86_ifd_pkg::t_fetch_rsp n2_rsp;

    always_comb begin
        s2_icode   = r1_req.first_byte[7:4];
        s2_ifun    = r1_req.first_byte[3:0];
        s2_hi      = r1_req.second_byte[7:4];
        s2_lo      = r1_req.second_byte[3:0];
        s2_len     = y86_ifd_pkg::len_of_icode(s2_icode);
        s2_range   = r1_diff[64] || (r1_diff[63:0] == 64'd0);
        s2_invalid = (s2_len == 4'd0) ||
                     (((s2_icode == y86_ifd_pkg::IC_RRMOVQ) ||
                       (s2_icode == y86_ifd_pkg::IC_OPQ) ||
                       (s2_icode == y86_ifd_pkg::IC_JXX)) &&
                      (s2_ifun > y86_ifd_pkg::FUN_MAX));
        s2_short   = (r1_diff[63:4] == 60'd0) && (r1_diff[3:0] < s2_len);

        n2_rsp.status         = y86_ifd_pkg::ST_OK;
        n2_rsp.icode          = s2_icode;
        n2_rsp.ifun           = s2_ifun;
        n2_rsp.reg_a          = y86_ifd_pkg::NO_REG;
        n2_rsp.reg_b          = y86_ifd_pkg::NO_REG;
        n2_rsp.constant_value = 64'd0;
        n2_rsp.next_pc        = 64'd0;
        n2_len                = 4'd0;

        if (s2_range) begin
            n2_rsp.status = y86_ifd_pkg::ST_RANGE;
            n2_rsp.icode  = 4'd0;
            n2_rsp.ifun   = 4'd0;
        end else if (s2_invalid) begin
            n2_rsp.status = y86_ifd_pkg::ST_INVALID;
        end else if (s2_short) begin
            n2_rsp.status = y86_ifd_pkg::ST_SHORT;
        end else begin
            n2_len = s2_len;
            if (s2_icode == y86_ifd_pkg::IC_HALT) begin
                n2_rsp.status = y86_ifd_pkg::ST_HALT;
            end
            unique case (s2_icode)
                y86_ifd_pkg::IC_RRMOVQ, y86_ifd_pkg::IC_OPQ: begin
                    n2_rsp.reg_a = s2_hi;
                    n2_rsp.reg_b = s2_lo;
                end
                y86_ifd_pkg::IC_IRMOVQ: begin
                    n2_rsp.reg_b          = s2_lo;
                    n2_rsp.constant_value = r1_req.following_quad;
                end
                y86_ifd_pkg::IC_RMMOVQ, y86_ifd_pkg::IC_MRMOVQ: begin
                    n2_rsp.reg_a          = s2_hi;
                    n2_rsp.reg_b          = s2_lo;
                    n2_rsp.constant_value = r1_req.following_quad;
                end
                y86_ifd_pkg::IC_JXX, y86_ifd_pkg::IC_CALL: begin
                    n2_rsp.constant_value = {r1_req.following_quad[55:0],
                                             r1_req.second_byte};
                end
                y86_ifd_pkg::IC_PUSHQ, y86_ifd_pkg::IC_POPQ: begin
                    n2_rsp.reg_a = s2_hi;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_rsp <= n2_rsp;
            r2_pc  <= r1_req.pc;
            r2_len <= n2_len;
        end
    end

    // Stage 3: next pc
    y86_ifd_pkg::t_fetch_rsp n3_rsp;

    always_comb begin
        n3_rsp         = r2_rsp;
        n3_rsp.next_pc = r2_pc + {60'd0, r2_len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_rsp <= n3_rsp;
        end
    end

endmodule

FILE: sim/y86_instruction_fetch_decode_unit_tb.sv
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode unit testbench
// Sends decode requests over the valid/stall request channel, predicts each
// response from the request and the shadowed program size, and checks every
// response field in order. Covers out-of-range, invalid, too-short, halt and
// every instruction length, then random requests clustered near the end of
// the program under three idle/stall mixes and several program sizes.
// ----------------------------------------------------------------------------
module y86_instruction_fetch_decode_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import y86_ifd_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIXED_QUAD     = 64'h0123_4567_89AB_CDEF;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [63:0] i_cfg_wdata = '0;
    logic        i_req_valid = 1'b0;
    logic        o_req_stall;
    t_fetch_req  i_req       = '0;
    logic        o_rsp_valid;
    logic        i_rsp_stall = 1'b0;
    t_fetch_rsp  o_rsp;

    t_fetch_rsp  pending_decodes[$];
    t_fetch_rsp  expected_rsp;
    logic [63:0] program_size_shadow = '0;
    int          req_idle_pct        = 0;
    int          rsp_stall_pct       = 0;
    int          error_count         = 0;
    int          requests_sent       = 0;
    int          responses_checked   = 0;
    int          sizes_written       = 0;
    int          idle_cycles         = 0;

    y86_instruction_fetch_decode_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_fetch_rsp decode_expected(input t_fetch_req req,
                                                   input logic [63:0] size);
        t_fetch_rsp rsp;
        logic [3:0] icode;
        logic [3:0] ifun;
        logic [3:0] nbytes;
        logic       bad_fun;
        icode              = req.first_byte[7:4];
        ifun               = req.first_byte[3:0];
        rsp.status         = ST_OK;
        rsp.icode          = icode;
        rsp.ifun           = ifun;
        rsp.reg_a          = NO_REG;
        rsp.reg_b          = NO_REG;
        rsp.constant_value = '0;
        rsp.next_pc        = req.pc;
        if (req.pc >= size) begin
            rsp.status = ST_RANGE;
            rsp.icode  = '0;
            rsp.ifun   = '0;
            return rsp;
        end
        case (icode)
            IC_HALT, IC_NOP, IC_RET:                   nbytes = 4'd1;
            IC_RRMOVQ, IC_OPQ, IC_PUSHQ, IC_POPQ:      nbytes = 4'd2;
            IC_JXX, IC_CALL:                           nbytes = 4'd9;
            IC_IRMOVQ, IC_RMMOVQ, IC_MRMOVQ:           nbytes = 4'd10;
            default:                                   nbytes = 4'd0;
        endcase
        bad_fun = (icode == IC_RRMOVQ || icode == IC_OPQ || icode == IC_JXX)
                  && (ifun > FUN_MAX);
        if (nbytes == 4'd0 || bad_fun) begin
            rsp.status = ST_INVALID;
            return rsp;
        end
        if (size - req.pc < 64'(nbytes)) begin
            rsp.status = ST_SHORT;
            return rsp;
        end
        case (icode)
            IC_RRMOVQ, IC_OPQ: begin
                rsp.reg_a = req.second_byte[7:4];
                rsp.reg_b = req.second_byte[3:0];
            end
            IC_IRMOVQ: begin
                rsp.reg_b          = req.second_byte[3:0];
                rsp.constant_value = req.following_quad;
            end
            IC_RMMOVQ, IC_MRMOVQ: begin
                rsp.reg_a          = req.second_byte[7:4];
                rsp.reg_b          = req.second_byte[3:0];
                rsp.constant_value = req.following_quad;
            end
            IC_JXX, IC_CALL: begin
                rsp.constant_value = {req.following_quad[55:0], req.second_byte};
            end
            IC_PUSHQ, IC_POPQ: begin
                rsp.reg_a = req.second_byte[7:4];
            end
            default: begin
            end
        endcase
        rsp.status  = (icode == IC_HALT) ? ST_HALT : ST_OK;
        rsp.next_pc = req.pc + 64'(nbytes);
        return rsp;
    endfunction

    function automatic t_fetch_req random_request(input logic [63:0] size);
        t_fetch_req  req;
        int unsigned pick;
        logic [3:0]  ic;
        logic [3:0]  fn;
        pick = $urandom_range(99);
        if (pick < 60 && size >= 64'd12) begin
            req.pc = size - 64'($urandom_range(12, 1));
        end else if (pick < 85 && size != 64'd0) begin
            req.pc = {$urandom, $urandom} % size;
        end else begin
            req.pc = {$urandom, $urandom};
        end
        if ($urandom_range(99) < 80) begin
            ic = 4'($urandom_range(11));
            fn = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(6));
            req.first_byte = {ic, fn};
        end else begin
            req.first_byte = 8'($urandom);
        end
        req.second_byte    = 8'($urandom);
        req.following_quad = {$urandom, $urandom};
        return req;
    endfunction

    function automatic t_fetch_req make_request(input logic [63:0] pc,
                                                input logic [7:0]  b0,
                                                input logic [7:0]  b1,
                                                input logic [63:0] quad);
        t_fetch_req req;
        req.pc             = pc;
        req.first_byte     = b0;
        req.second_byte    = b1;
        req.following_quad = quad;
        return req;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        i_rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid === 1'b1 && i_rsp_stall === 1'b0) begin
            if (pending_decodes.size() == 0) begin
                $error("response with no request pending: status 0x%0h pc 0x%0h",
                       o_rsp.status, o_rsp.next_pc);
                error_count++;
            end else begin
                expected_rsp = pending_decodes.pop_front();
                check_field("status", 64'(expected_rsp.status), 64'(o_rsp.status));
                check_field("icode", 64'(expected_rsp.icode), 64'(o_rsp.icode));
                check_field("ifun", 64'(expected_rsp.ifun), 64'(o_rsp.ifun));
                check_field("reg_a", 64'(expected_rsp.reg_a), 64'(o_rsp.reg_a));
                check_field("reg_b", 64'(expected_rsp.reg_b), 64'(o_rsp.reg_b));
                check_field("constant_value", expected_rsp.constant_value,
                            o_rsp.constant_value);
                check_field("next_pc", expected_rsp.next_pc, o_rsp.next_pc);
                responses_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, pending_decodes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input t_fetch_req req);
        while ($urandom_range(99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (o_req_stall);
        pending_decodes.push_back(decode_expected(req, program_size_shadow));
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (pending_decodes.size() != 0);
    endtask

    task automatic write_program_size(input logic [63:0] size);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we            <= 1'b0;
        program_size_shadow  = size;
        sizes_written++;
    endtask

    task automatic test_out_of_range();
        write_program_size(64'd0);
        send_request(make_request(64'd0, {IC_NOP, 4'h0}, 8'h00, 64'd0));
        send_request(make_request(ALL_ONES, 8'hFF, 8'hFF, ALL_ONES));
        write_program_size(ALL_ONES);
        send_request(make_request(ALL_ONES, {IC_IRMOVQ, 4'h0}, 8'hF3, ALL_ONES));
        send_request(make_request(ALL_ONES - 64'd1, {IC_HALT, 4'h0}, 8'h00, 64'd0));
        send_request(make_request(ALL_ONES - 64'd9, {IC_CALL, 4'h0}, 8'hFF, ALL_ONES));
    endtask

    task automatic test_every_icode();
        logic [3:0] ic;
        write_program_size(64'd64);
        for (int i = 0; i < 16; i++) begin
            ic = 4'(i);
            send_request(make_request(64'(2 * i), {ic, 4'(i % 7)}, {~ic, ic},
                                      (i % 2 == 0) ? ALL_ONES : MIXED_QUAD));
        end
    endtask

    task automatic test_bad_function();
        send_request(make_request(64'd0, {IC_RRMOVQ, 4'h7}, 8'h12, MIXED_QUAD));
        send_request(make_request(64'd0, {IC_OPQ, 4'hF}, 8'h34, MIXED_QUAD));
        send_request(make_request(64'd0, {IC_JXX, 4'h7}, 8'h56, MIXED_QUAD));
        send_request(make_request(64'd0, {IC_NOP, 4'hF}, 8'h78, MIXED_QUAD));
    endtask

    task automatic test_too_short();
        send_request(make_request(64'd63, {IC_IRMOVQ, 4'h0}, 8'hF1, ALL_ONES));
        send_request(make_request(64'd54, {IC_IRMOVQ, 4'h0}, 8'hF1, ALL_ONES));
        send_request(make_request(64'd56, {IC_JXX, 4'h3}, 8'hAA, MIXED_QUAD));
        send_request(make_request(64'd62, {IC_RRMOVQ, 4'h2}, 8'h9C, 64'd0));
        send_request(make_request(64'd63, 8'hE5, 8'h00, 64'd0));
    endtask

    task automatic test_random_phase(input int n_items, input int sender_pct,
                                     input int receiver_pct);
        logic [63:0] size;
        req_idle_pct  = sender_pct;
        rsp_stall_pct = receiver_pct;
        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0:       size = 64'($urandom_range(4096, 16));
                1:       size = {$urandom, $urandom};
                default: size = ALL_ONES;
            endcase
            write_program_size(size);
            for (int n = 0; n < n_items / 3; n++) begin
                if ($urandom_range(199) == 0) begin
                    wait_for_drain();
                end
                send_request(random_request(program_size_shadow));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        req_idle_pct  = 6;
        rsp_stall_pct = 72;
        test_out_of_range();
        test_every_icode();
        test_bad_function();
        test_too_short();

        test_random_phase(630, 6, 72);
        test_random_phase(630, 72, 6);
        test_random_phase(630, 0, 0);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d decode requests and checked %0d responses across %0d program sizes,",
                 requests_sent, responses_checked, sizes_written);
        $display("including every icode, bad ifun, short tails and out-of-range pcs.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
